FILE: design/lru_key_value_cache_defines.svh
// assertion macros for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// property must hold whenever out of reset
`define LKV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked also during reset
`define LKV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/lkv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_pkg
// types and constants shared by the lru key-value cache modules
// ----------------------------------------------------------------------------
package lkv_pkg;
  localparam int ENTRIES   = 16;
  localparam int KEY_WIDTH = 16;
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int CNT_W     = $clog2(ENTRIES + 1);
  localparam int CAP_W     = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_SET = 1'b1;

  typedef struct packed {
    logic              func;
    logic [15:0]       key;
    logic signed [31:0] data_in;
  } lkv_in_t;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] data_out;
  } lkv_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE,
    ST_RESULT
  } lkv_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture an input word
    logic lookup;   // register the key match
    logic update;   // apply a set
    logic respond;  // load the output register
  } lkv_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_set;
  } lkv_status_t;
endpackage
`default_nettype wire

FILE: design/lkv_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_ctrl
// sequencer: load, lookup, update or respond, one word at a time
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"
module lkv_ctrl import lkv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        out_ready,
  output      logic        out_valid,
  input  wire lkv_status_t status,
  output      lkv_cmd_t    cmd
);
  lkv_state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = status.is_set ? ST_UPDATE : ST_RESULT;
      ST_UPDATE: state_next = ST_IDLE;
      ST_RESULT: if (!out_valid || out_ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_RESULT: cmd.respond = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.respond) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  `LKV_ASSERT(a_update_only_after_lookup, cmd.update |-> $past(cmd.lookup), "update w/o lookup")
  `LKV_ASSERT(a_respond_gives_valid, cmd.respond |=> out_valid, "respond lost")
  `LKV_ASSERT(a_no_accept_busy, (state != ST_IDLE) |-> !in_ready, "accept while busy")
endmodule
`default_nettype wire

FILE: design/lkv_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkv_datapath
// entry registers, key match, recency ranks and output register
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"
module lkv_datapath import lkv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire lkv_cmd_t         cmd,
  input  wire lkv_in_t          in_word,
  input  wire logic [CAP_W-1:0] capacity,
  output      lkv_status_t      status,
  output      lkv_out_t         out_word
);
  logic [ENTRIES-1:0]   valid;
  logic [KEY_WIDTH-1:0] keys [ENTRIES];
  logic [31:0]          vals [ENTRIES];
  logic [IDX_W-1:0]     rank [ENTRIES];
  logic [CNT_W-1:0]     occupancy;
  lkv_in_t              cur;

  // lookup results, registered
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic [IDX_W-1:0]     found_rank;
  logic [IDX_W-1:0]     victim_idx;
  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;

  logic [ENTRIES-1:0]   match;
  logic                 m_any, v_any, f_any;
  logic [IDX_W-1:0]     m_idx, v_idx, f_idx;
  logic [CNT_W-1:0]     eff_cap;
  logic                 full;

  assign status.is_set = (cur.func == FUNC_SET);

  // capture input word
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_word;
  end

  // parallel key compare, oldest-entry search and free-slot search
  always_comb begin
    m_any = 1'b0; m_idx = '0;
    v_any = 1'b0; v_idx = '0;
    f_any = 1'b0; f_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == cur.key[KEY_WIDTH-1:0]);
      if (match[i] && !m_any) begin
        m_any = 1'b1; m_idx = IDX_W'(i);
      end
      // oldest valid entry holds the top rank occupancy-1
      if (valid[i] && (CNT_W'(rank[i]) == occupancy - CNT_W'(1)) && !v_any) begin
        v_any = 1'b1; v_idx = IDX_W'(i);
      end
      if (!valid[i] && !f_any) begin
        f_any = 1'b1; f_idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      found      <= m_any;
      found_idx  <= m_idx;
      found_rank <= rank[m_idx];
      victim_idx <= v_idx;
      free_any   <= f_any;
      free_idx   <= f_idx;
    end
  end

  // effective capacity clamp
  always_comb begin
    if (capacity == '0) eff_cap = CNT_W'(1);
    else if (32'(capacity) > ENTRIES) eff_cap = CNT_W'(ENTRIES);
    else eff_cap = CNT_W'(capacity);
  end
  assign full = (occupancy >= eff_cap) && (occupancy != '0);

  // set: refresh a present key, or insert, evicting the oldest when full
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occupancy <= '0;
      for (int i = 0; i < ENTRIES; i++) rank[i] <= '0;
    end else if (cmd.update) begin
      if (found) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i] && rank[i] < found_rank) rank[i] <= rank[i] + IDX_W'(1);
        rank[found_idx] <= '0;
        vals[found_idx] <= cur.data_in;
      end else if (full) begin
        // victim slot reused: all others age, victim becomes newest
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i]) rank[i] <= rank[i] + IDX_W'(1);
        rank[victim_idx] <= '0;
        keys[victim_idx] <= cur.key[KEY_WIDTH-1:0];
        vals[victim_idx] <= cur.data_in;
      end else if (free_any) begin
        for (int i = 0; i < ENTRIES; i++)
          if (valid[i]) rank[i] <= rank[i] + IDX_W'(1);
        valid[free_idx] <= 1'b1;
        rank[free_idx]  <= '0;
        keys[free_idx]  <= cur.key[KEY_WIDTH-1:0];
        vals[free_idx]  <= cur.data_in;
        occupancy <= occupancy + CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      out_word.hit      <= found;
      out_word.data_out <= found ? vals[found_idx] : MISS_VALUE;
    end
  end

  `LKV_ASSERT(a_occ_matches_valid, occupancy == CNT_W'($countones(valid)), "occupancy off")
  `LKV_ASSERT(a_occ_bound, occupancy <= CNT_W'(ENTRIES), "occupancy overflow")
  `LKV_ASSERT(a_one_match, $onehot0(match), "duplicate key")
endmodule
`default_nettype wire

FILE: design/lru_key_value_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// fully associative key-value store with least-recently-set eviction
// ----------------------------------------------------------------------------
// in_valid/in_ready carry a word {func, key, data_in}; func 1 is a set,
// func 0 a get. a set gives no result; a get gives one {hit, data_out}
// word on out_valid/out_ready, data_out all ones on a miss.
// a word steps through accept, key compare, then update or result load;
// the sequencer takes one word at a time through the 16-entry compare.
// on a get the lookup result is registered first; out_valid rises as the output register loads.
// cfg_valid/cfg_ready write the capacity register (always ready); write it
// only while idle. zero acts as one, above 16 acts as 16.
// reset empties the store and sets capacity to 16, no clearing pass.
// when the receiver stalls the result waits in the output register; the
// next word is taken, but its result holds until the register frees.
// ----------------------------------------------------------------------------
module lru_key_value_cache import lkv_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire lkv_in_t          in_data,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      lkv_out_t         out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);
  logic [CAP_W-1:0] capacity;
  lkv_cmd_t         cmd;
  lkv_status_t      status;

  assign cfg_ready = 1'b1;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (cfg_valid) capacity <= cfg_data;
  end

  lkv_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_ready, .out_valid,
    .status, .cmd
  );

  lkv_datapath u_dp (
    .clk, .rst, .cmd, .in_word(in_data), .capacity,
    .status, .out_word(out_data)
  );
endmodule
`default_nettype wire

FILE: dv/lkv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkv_checker
// watches the input, result and capacity channels of the lru key-value
// cache, keeps its own copy of the store and compares every result word
// ----------------------------------------------------------------------------
module lkv_checker import lkv_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input lkv_in_t          in_data,
  input logic             out_valid,
  input logic             out_ready,
  input lkv_out_t         out_data,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CAP_W-1:0] cfg_data,
  output int              fail_count,
  output int              pending
);
  // model of the store
  logic [CAP_W-1:0] cap_reg;
  logic             slot_used [ENTRIES];
  logic [15:0]      slot_key [ENTRIES];
  logic [31:0]      slot_val [ENTRIES];
  int unsigned      slot_age [ENTRIES];
  int unsigned      fill;
  lkv_out_t         lookup_q [$];

  assign pending = lookup_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic int find_slot(input logic [15:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  // apply a set word to the model
  task automatic store_word(input logic [15:0] k, input logic [31:0] v);
    int s;
    int victim;
    int unsigned lim;
    s = find_slot(k);
    victim = -1;
    lim = (cap_reg == 0) ? 1 : (cap_reg > ENTRIES) ? ENTRIES : cap_reg;
    if (s >= 0) begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && slot_age[i] < slot_age[s]) slot_age[i]++;
      slot_age[s] = 0;
      slot_val[s] = v;
      return;
    end
    if (fill >= lim && fill > 0) begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && (victim < 0 || slot_age[i] > slot_age[victim])) victim = i;
      if (victim >= 0) begin
        slot_used[victim] = 1'b0;
        slot_age[victim] = 0;
        fill--;
      end
    end
    for (int i = 0; i < ENTRIES; i++)
      if (!slot_used[i]) begin
        s = i;
        break;
      end
    if (s < 0) return;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i]) slot_age[i]++;
    slot_used[s] = 1'b1;
    slot_key[s] = k;
    slot_val[s] = v;
    slot_age[s] = 0;
    fill++;
  endtask

  always @(posedge clk) begin
    int s;
    lkv_out_t want;
    lkv_out_t got;
    if (rst) begin
      cap_reg = CAP_RESET;
      fill = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        slot_used[i] = 1'b0;
        slot_age[i] = 0;
      end
      lookup_q.delete();
      fail_count = 0;
    end else begin
      // result word check
      if (out_valid && out_ready) begin
        got = out_data;
        if (lookup_q.size() == 0) begin
          report("unexpected result", got.data_out, 32'h0);
        end else begin
          want = lookup_q.pop_front();
          if (got.hit !== want.hit) report("hit", got.hit, want.hit);
          if (got.data_out !== want.data_out) report("data_out", got.data_out, want.data_out);
        end
      end
      // input word
      if (in_valid && in_ready) begin
        if (in_data.func == FUNC_SET) begin
          store_word(in_data.key, in_data.data_in);
        end else begin
          s = find_slot(in_data.key);
          want.hit = (s >= 0);
          want.data_out = (s >= 0) ? slot_val[s] : MISS_VALUE;
          lookup_q.push_back(want);
        end
      end
      if (cfg_valid && cfg_ready) cap_reg = cfg_data;
    end
  end
endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives sets, gets and capacity changes into the lru key-value cache;
// the checker beside the block predicts and compares the results
// ----------------------------------------------------------------------------
module tb;
  import lkv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  lkv_in_t          in_data;
  logic             out_valid;
  logic             out_ready;
  lkv_out_t         out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;
  int               fail_count;
  int               pending;
  int               cycles;
  bit               calm;
  logic [15:0]      key_pool [8];

  lru_key_value_cache dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  lkv_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // timeout
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // receiver stalls in bursts
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // send one word, with an occasional gap first
  task automatic send_word(input logic f, input logic [15:0] k, input logic [31:0] v);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: f, key: k, data_in: v};
    // ready is stable from the falling edge to the next rising edge
    while (!in_ready) @(negedge clk);
    @(negedge clk);
  endtask

  // drain, then write capacity
  task automatic set_capacity(input logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    while (!cfg_ready) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random word drawn mostly from a small key pool so hits and evictions happen
  task automatic random_word();
    logic [15:0] k;
    k = ($urandom_range(0, 9) == 0) ? 16'($urandom) : key_pool[$urandom_range(0, 7)];
    send_word(($urandom_range(0, 1) == 1) ? FUNC_SET : FUNC_GET, k, $urandom);
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty miss, key and value extremes, overwrite, capacity one
    send_word(FUNC_GET, 16'h0000, 32'h0);
    send_word(FUNC_SET, 16'h0000, 32'h8000_0000);
    send_word(FUNC_SET, 16'hFFFF, 32'h7FFF_FFFF);
    send_word(FUNC_GET, 16'h0000, 32'hFFFF_FFFF);
    send_word(FUNC_GET, 16'hFFFF, 32'h0);
    send_word(FUNC_SET, 16'h0000, 32'hFFFF_FFFF);
    send_word(FUNC_GET, 16'h0000, 32'h0);
    send_word(FUNC_GET, 16'h1234, 32'h0);
    // capacity lowered below occupancy
    set_capacity(5'd1);
    send_word(FUNC_SET, 16'h00AA, 32'h1);
    send_word(FUNC_GET, 16'h0000, 32'h0);
    send_word(FUNC_GET, 16'hFFFF, 32'h0);
    send_word(FUNC_GET, 16'h00AA, 32'h0);
    send_word(FUNC_SET, 16'h00AA, 32'h2);
    send_word(FUNC_GET, 16'h00AA, 32'h0);
    set_capacity(5'd0);
    send_word(FUNC_SET, 16'h5555, 32'h3);
    send_word(FUNC_SET, 16'hAAAA, 32'h4);
    send_word(FUNC_GET, 16'h5555, 32'h0);
    send_word(FUNC_GET, 16'hAAAA, 32'h0);
    set_capacity(5'd31);

    // random phases across capacities
    for (int ph = 0; ph < 7; ph++) begin
      set_capacity((ph == 6) ? 5'd16 : 5'($urandom_range(1, 20)));
      for (int j = 0; j < 8; j++)
        key_pool[j] = (ph % 2 == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 90; n++) random_word();
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
